@@ rtl/sprite_frame_sequencer_top_assert.svh @@
// Assertion macros shared by the sprite frame sequencer RTL.
// Included by sfs_dp, which checks its own behaviour; no other dependencies.
`ifndef SPRITE_FRAME_SEQUENCER_TOP_ASSERT_SVH
`define SPRITE_FRAME_SEQUENCER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sfs_pkg.sv @@
// Package for the sprite frame sequencer: field widths, codes and control types.
// No dependencies; used by every module of the block except sfs_ram.
`timescale 1ns / 1ps
`default_nettype none

package sfs_pkg;

    localparam int TIME_W         = 32;
    localparam int FRAME_W        = 8;
    localparam int STATE_W        = 6;
    localparam int SLOT_W         = 6;
    localparam int REQ_W          = 16;
    localparam int COUNT_W        = 7;
    localparam int MAX_STATES_DEF = 64;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;

    typedef enum logic [1:0] {
        KIND_TICK      = 2'd0,
        KIND_LOAD      = 2'd1,
        KIND_SET_STATE = 2'd2,
        KIND_SET_TIME  = 2'd3
    } kind_t;

    typedef enum logic {
        REG_STATE_COUNT    = 1'b0,
        REG_ANIMATE_ENABLE = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_WALK,
        ST_MOD,
        ST_FIN
    } ctrl_state_t;

    typedef logic [STATE_W-1:0] state_idx_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic read;
        logic step;
        logic mod_start;
        logic mod_apply;
        logic out_load;
    } sfs_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  animate;
        logic  walk_stop;
        logic  lap_full;
        logic  mod_done;
        logic  out_free;
    } sfs_status_t;

endpackage

`default_nettype wire

@@ rtl/sprite_frame_sequencer_top.sv @@
// Sequence: an accepted item is captured, then executed; a load writes its table entry and
// then re-reads the current state's, a tick or seek walks state by state, and a set-state
// item or an ignored tick goes on to the result. A walk that covers a whole lap of the table
// folds the time, then takes at most n-1 steps. Items are handled one at a time.
// Reset: synchronous active-low aresetn clears state and time to 0, state_count to 1 and
// animate_enable to 0; the frame and hold tables are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module sprite_frame_sequencer_top #(
    parameter int MAX_STATES = sfs_pkg::MAX_STATES_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [sfs_pkg::APB_AW-1:0]       paddr,
    input  wire logic [sfs_pkg::APB_DW-1:0]       pwdata,
    output logic      [sfs_pkg::APB_DW-1:0]       prdata,
    output logic                                  pready,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [1:0]                       s_kind,
    input  wire logic [sfs_pkg::TIME_W-1:0]       s_time_value,
    input  wire logic [sfs_pkg::SLOT_W-1:0]       s_entry_index,
    input  wire logic [sfs_pkg::FRAME_W-1:0]      s_entry_frame,
    input  wire logic [sfs_pkg::TIME_W-1:0]       s_entry_delay,
    input  wire logic signed [sfs_pkg::REQ_W-1:0] s_new_state,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic      [sfs_pkg::STATE_W-1:0]      m_state_index,
    output logic      [sfs_pkg::FRAME_W-1:0]      m_frame_number,
    output logic      [sfs_pkg::TIME_W-1:0]       m_time_in_state,
    output logic                                  m_bad_index
);

    localparam int CountW = sfs_pkg::COUNT_W;
    localparam int ApbDw  = sfs_pkg::APB_DW;

    logic [CountW-1:0]    state_count_reg, state_count_next;
    logic                 animate_enable_reg, animate_enable_next;
    logic                 cfg_wr;
    sfs_pkg::reg_idx_t    reg_idx;
    sfs_pkg::sfs_cmd_t    cmd;
    sfs_pkg::sfs_status_t status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = sfs_pkg::reg_idx_t'(paddr[2]);

    always_comb begin
        state_count_next    = state_count_reg;
        animate_enable_next = animate_enable_reg;
        if (cfg_wr) begin
            case (reg_idx)
                sfs_pkg::REG_STATE_COUNT: begin
                    state_count_next = pwdata[CountW-1:0];
                end
                sfs_pkg::REG_ANIMATE_ENABLE: begin
                    animate_enable_next = pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            sfs_pkg::REG_STATE_COUNT: begin
                prdata = ApbDw'(state_count_reg);
            end
            sfs_pkg::REG_ANIMATE_ENABLE: begin
                prdata = ApbDw'(animate_enable_reg);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_count_reg    <= CountW'(1);
            animate_enable_reg <= 1'b0;
        end else begin
            state_count_reg    <= state_count_next;
            animate_enable_reg <= animate_enable_next;
        end
    end

    sfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sfs_dp #(
        .MAX_STATES (MAX_STATES)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .state_count     (state_count_reg),
        .animate_enable  (animate_enable_reg),
        .s_kind          (s_kind),
        .s_time_value    (s_time_value),
        .s_entry_index   (s_entry_index),
        .s_entry_frame   (s_entry_frame),
        .s_entry_delay   (s_entry_delay),
        .s_new_state     (s_new_state),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_state_index   (m_state_index),
        .m_frame_number  (m_frame_number),
        .m_time_in_state (m_time_in_state),
        .m_bad_index     (m_bad_index)
    );

endmodule

`default_nettype wire

@@ rtl/sfs_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sfs_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/sfs_urem.sv @@
// Bit-serial remainder unit: one dividend bit per cycle against a wide divisor.
// Depends on sfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfs_urem #(
    parameter int DIV_W = 38
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [sfs_pkg::TIME_W-1:0] dividend,
    input  wire logic [DIV_W-1:0]           divisor,
    output logic                            done,
    output logic      [sfs_pkg::TIME_W-1:0] remainder
);

    localparam int TimeW = sfs_pkg::TIME_W;
    localparam int CntW  = $clog2(TimeW);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic [TimeW-1:0] quo_reg, quo_next;
    logic [TimeW-1:0] rem_reg, rem_next;
    logic [TimeW:0]   shifted;
    logic [DIV_W-1:0] shifted_ext;
    logic [DIV_W-1:0] diff;
    logic             fits;

    always_comb begin
        shifted     = {rem_reg, quo_reg[TimeW-1]};
        shifted_ext = DIV_W'(shifted);
        fits        = shifted_ext >= divisor;
        diff        = shifted_ext - divisor;

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            quo_next = {quo_reg[TimeW-2:0], 1'b0};
            rem_next = fits ? diff[TimeW-1:0] : shifted[TimeW-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(TimeW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

@@ rtl/sfs_dp.sv @@
// Datapath of the sprite frame sequencer: item registers, state and time, table RAM,
// remainder unit and output register. Depends on sfs_pkg, sfs_ram and sfs_urem.
`timescale 1ns / 1ps
`default_nettype none

module sfs_dp #(
    parameter int MAX_STATES = sfs_pkg::MAX_STATES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire sfs_pkg::sfs_cmd_t                 cmd,
    output sfs_pkg::sfs_status_t                   status,
    input  wire logic [sfs_pkg::COUNT_W-1:0]       state_count,
    input  wire logic                              animate_enable,
    input  wire logic [1:0]                        s_kind,
    input  wire logic [sfs_pkg::TIME_W-1:0]        s_time_value,
    input  wire logic [sfs_pkg::SLOT_W-1:0]        s_entry_index,
    input  wire logic [sfs_pkg::FRAME_W-1:0]       s_entry_frame,
    input  wire logic [sfs_pkg::TIME_W-1:0]        s_entry_delay,
    input  wire logic signed [sfs_pkg::REQ_W-1:0]  s_new_state,
    input  wire logic                              m_ready,
    output logic                                   m_valid,
    output logic      [sfs_pkg::STATE_W-1:0]       m_state_index,
    output logic      [sfs_pkg::FRAME_W-1:0]       m_frame_number,
    output logic      [sfs_pkg::TIME_W-1:0]        m_time_in_state,
    output logic                                   m_bad_index
);

    localparam int TimeW  = sfs_pkg::TIME_W;
    localparam int FrameW = sfs_pkg::FRAME_W;
    localparam int SlotW  = sfs_pkg::SLOT_W;
    localparam int ReqW   = sfs_pkg::REQ_W;
    localparam int CountW = sfs_pkg::COUNT_W;
    localparam int IdxW   = $clog2(MAX_STATES);
    localparam int NW     = $clog2(MAX_STATES + 1);
    localparam int LapW   = TimeW + IdxW;
    localparam int RamW   = FrameW + TimeW;
    localparam int CmpW   = (NW > CountW) ? NW : CountW;
    localparam int SlotCW = (NW > SlotW) ? NW : SlotW;

    sfs_pkg::kind_t    kind_reg, kind_next;
    logic [TimeW-1:0]  tval_reg, tval_next;
    logic [SlotW-1:0]  slot_reg, slot_next;
    logic [FrameW-1:0] efrm_reg, efrm_next;
    logic [TimeW-1:0]  delay_reg, delay_next;
    logic [ReqW-1:0]   req_reg, req_next;
    logic [IdxW-1:0]   cur_reg, cur_next;
    logic [TimeW-1:0]  t_reg, t_next;
    logic              bad_reg, bad_next;
    logic [LapW-1:0]   lap_reg, lap_next;
    logic [NW-1:0]     steps_reg, steps_next;
    logic              m_valid_reg, m_valid_next;
    logic [sfs_pkg::STATE_W-1:0] m_state_reg, m_state_next;
    logic [FrameW-1:0] m_frame_reg, m_frame_next;
    logic [TimeW-1:0]  m_time_reg, m_time_next;
    logic              m_bad_reg, m_bad_next;

    logic [CmpW-1:0]   sc_ext;
    logic [NW-1:0]     n;
    logic              n_le1;
    logic [RamW-1:0]   rd_data;
    logic [FrameW-1:0] rd_frame;
    logic [TimeW-1:0]  rd_hold;
    logic [TimeW-1:0]  hold_h;
    logic [TimeW:0]    sum_ext;
    logic [TimeW-1:0]  sat_sum;
    logic              req_neg;
    logic              req_big;
    logic [IdxW-1:0]   clamp_cur;
    logic [IdxW-1:0]   ex_cur;
    logic              stale;
    logic [NW-1:0]     cur_inc;
    logic [IdxW-1:0]   step_cur;
    logic              slot_ok;
    logic              ram_we;
    logic              ram_re;
    logic [IdxW-1:0]   ram_raddr;
    logic              mod_done;
    logic [TimeW-1:0]  mod_rem;

    // The live count clamps a zero register to one and a large one to the table size.
    always_comb begin
        sc_ext = CmpW'(state_count);
        if (sc_ext == '0) begin
            n = NW'(1);
        end else if (sc_ext > CmpW'(MAX_STATES)) begin
            n = NW'(MAX_STATES);
        end else begin
            n = NW'(sc_ext);
        end
    end

    assign n_le1    = n <= NW'(1);
    assign rd_frame = rd_data[RamW-1 -: FrameW];
    assign rd_hold  = rd_data[TimeW-1:0];
    assign hold_h   = (rd_hold == '0) ? TimeW'(1) : rd_hold;

    assign sum_ext = {1'b0, t_reg} + {1'b0, tval_reg};
    assign sat_sum = sum_ext[TimeW] ? '1 : sum_ext[TimeW-1:0];

    assign req_neg   = req_reg[ReqW-1];
    assign req_big   = !req_neg && (req_reg >= ReqW'(n));
    assign clamp_cur = req_neg ? '0 : (req_big ? IdxW'(n - NW'(1)) : IdxW'(req_reg));

    always_comb begin
        case (kind_reg)
            sfs_pkg::KIND_SET_STATE: begin
                ex_cur = clamp_cur;
            end
            sfs_pkg::KIND_SET_TIME: begin
                ex_cur = '0;
            end
            default: begin
                ex_cur = cur_reg;
            end
        endcase
    end

    // A state left beyond a lowered count takes one step straight back to state 0.
    assign stale    = NW'(cur_reg) >= n;
    assign cur_inc  = NW'(cur_reg) + NW'(1);
    assign step_cur = (stale || (cur_inc >= n)) ? '0 : IdxW'(cur_inc);

    assign slot_ok   = SlotCW'(slot_reg) < SlotCW'(MAX_STATES);
    assign ram_we    = cmd.exec && (kind_reg == sfs_pkg::KIND_LOAD) && slot_ok;
    assign ram_re    = cmd.exec || cmd.step || cmd.read;
    assign ram_raddr = cmd.exec ? ex_cur : (cmd.step ? step_cur : cur_reg);

    sfs_ram #(
        .WIDTH (RamW),
        .DEPTH (MAX_STATES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (IdxW'(slot_reg)),
        .wdata ({efrm_reg, delay_reg}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    sfs_urem #(
        .DIV_W (LapW)
    ) u_urem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.mod_start),
        .dividend  (t_reg - TimeW'(1)),
        .divisor   (lap_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb begin
        kind_next    = kind_reg;
        tval_next    = tval_reg;
        slot_next    = slot_reg;
        efrm_next    = efrm_reg;
        delay_next   = delay_reg;
        req_next     = req_reg;
        cur_next     = cur_reg;
        t_next       = t_reg;
        bad_next     = bad_reg;
        lap_next     = lap_reg;
        steps_next   = steps_reg;
        m_valid_next = m_valid_reg;
        m_state_next = m_state_reg;
        m_frame_next = m_frame_reg;
        m_time_next  = m_time_reg;
        m_bad_next   = m_bad_reg;

        if (cmd.capture) begin
            kind_next  = sfs_pkg::kind_t'(s_kind);
            tval_next  = s_time_value;
            slot_next  = s_entry_index;
            efrm_next  = s_entry_frame;
            delay_next = s_entry_delay;
            req_next   = s_new_state;
        end

        if (cmd.exec) begin
            bad_next   = 1'b0;
            lap_next   = '0;
            steps_next = '0;
            case (kind_reg)
                sfs_pkg::KIND_TICK: begin
                    if (animate_enable) begin
                        t_next = sat_sum;
                    end
                end
                sfs_pkg::KIND_LOAD: begin
                end
                sfs_pkg::KIND_SET_STATE: begin
                    cur_next = clamp_cur;
                    t_next   = '0;
                    bad_next = req_neg || req_big;
                end
                sfs_pkg::KIND_SET_TIME: begin
                    cur_next = '0;
                    t_next   = tval_reg;
                end
                default: begin
                end
            endcase
        end

        if (cmd.step) begin
            t_next   = t_reg - hold_h;
            cur_next = step_cur;
            if (!stale) begin
                lap_next   = lap_reg + LapW'(hold_h);
                steps_next = steps_reg + 1'b1;
            end
        end

        if (cmd.mod_apply) begin
            t_next     = mod_rem + TimeW'(1);
            steps_next = '0;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            m_state_next = sfs_pkg::state_idx_t'(cur_reg);
            m_frame_next = rd_frame;
            m_time_next  = t_reg;
            m_bad_next   = bad_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg     <= '0;
            t_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cur_reg     <= cur_next;
            t_reg       <= t_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        tval_reg    <= tval_next;
        slot_reg    <= slot_next;
        efrm_reg    <= efrm_next;
        delay_reg   <= delay_next;
        req_reg     <= req_next;
        bad_reg     <= bad_next;
        lap_reg     <= lap_next;
        steps_reg   <= steps_next;
        m_state_reg <= m_state_next;
        m_frame_reg <= m_frame_next;
        m_time_reg  <= m_time_next;
        m_bad_reg   <= m_bad_next;
    end

    assign status.kind      = kind_reg;
    assign status.animate   = animate_enable;
    assign status.walk_stop = n_le1 || (t_reg <= hold_h);
    assign status.lap_full  = steps_reg == n;
    assign status.mod_done  = mod_done;
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid         = m_valid_reg;
    assign m_state_index   = m_state_reg;
    assign m_frame_number  = m_frame_reg;
    assign m_time_in_state = m_time_reg;
    assign m_bad_index     = m_bad_reg;

`include "sprite_frame_sequencer_top_assert.svh"

    `SFS_ASSERT_NEXT(a_step_in_table, aclk, aresetn, cmd.step, (NW'(cur_reg) < n), "state left the table after a step")
    `SFS_ASSERT_NEXT(a_fold_within_lap, aclk, aresetn, cmd.mod_apply, (LapW'(t_reg) <= lap_reg), "folded time exceeds one lap")
    `SFS_ASSERT_NOW(a_out_reg_free, aclk, aresetn, cmd.out_load, (!m_valid_reg || m_ready), "result overwrote an item not yet taken")

endmodule

`default_nettype wire

@@ rtl/sfs_ctrl.sv @@
// Controller of the sprite frame sequencer: sequences capture, execution, the state walk,
// lap folding and result hand-off. Depends on sfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfs_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire sfs_pkg::sfs_status_t status,
    output sfs_pkg::sfs_cmd_t         cmd
);

    sfs_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sfs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            sfs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = sfs_pkg::ST_EXEC;
                end
            end
            sfs_pkg::ST_EXEC: begin
                cmd.exec = 1'b1;
                if (status.kind == sfs_pkg::KIND_LOAD) begin
                    state_next = sfs_pkg::ST_READ;
                end else if ((status.kind == sfs_pkg::KIND_SET_TIME) ||
                             ((status.kind == sfs_pkg::KIND_TICK) && status.animate)) begin
                    state_next = sfs_pkg::ST_WALK;
                end else begin
                    state_next = sfs_pkg::ST_FIN;
                end
            end
            sfs_pkg::ST_READ: begin
                cmd.read   = 1'b1;
                state_next = sfs_pkg::ST_FIN;
            end
            sfs_pkg::ST_WALK: begin
                if (status.walk_stop) begin
                    state_next = sfs_pkg::ST_FIN;
                end else if (status.lap_full) begin
                    cmd.mod_start = 1'b1;
                    state_next    = sfs_pkg::ST_MOD;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            sfs_pkg::ST_MOD: begin
                if (status.mod_done) begin
                    cmd.mod_apply = 1'b1;
                    state_next    = sfs_pkg::ST_WALK;
                end
            end
            sfs_pkg::ST_FIN: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = sfs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sfs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
